// ===== rtl/audio_codec_touch_digitizer_defines.svh =====
// Assertion macros shared by the digitizer RTL.
`ifndef AUDIO_CODEC_TOUCH_DIGITIZER_DEFINES_SVH
`define AUDIO_CODEC_TOUCH_DIGITIZER_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define ACTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ACTD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/actd_pkg.sv =====
// Shared constants, codes and types of the codec touch digitizer.
package actd_pkg;

  localparam logic [2:0] OpRead  = 3'd0;
  localparam logic [2:0] OpWrite = 3'd1;
  localparam logic [2:0] OpTick  = 3'd2;
  localparam logic [2:0] OpPen   = 3'd3;
  localparam logic [2:0] OpAux   = 3'd4;

  localparam logic [6:0] AddrReset   = 7'h00;
  localparam logic [6:0] AddrRecSel  = 7'h1a;
  localparam logic [6:0] AddrGpr     = 7'h20;
  localparam logic [6:0] AddrPwrDn   = 7'h26;
  localparam logic [6:0] AddrExtAud  = 7'h2a;
  localparam logic [6:0] AddrDacRate = 7'h2c;
  localparam logic [6:0] AddrAdcRate = 7'h32;
  localparam logic [6:0] AddrMixMute = 7'h5a;
  localparam logic [6:0] AddrFuncCtl = 7'h5c;
  localparam logic [6:0] AddrExtraFn = 7'h74;
  localparam logic [6:0] AddrDig0    = 7'h76;
  localparam logic [6:0] AddrDig1    = 7'h78;
  localparam logic [6:0] AddrResult  = 7'h7a;
  localparam logic [6:0] AddrId1     = 7'h7c;
  localparam logic [6:0] AddrId2     = 7'h7e;

  localparam logic [15:0] ResetId   = 16'h6150;
  localparam logic [15:0] VendorId1 = 16'h574D;
  localparam logic [15:0] VendorId2 = 16'h4C05;

  // The level (mv*4095+1650)/3300 equals ((mv*273+110)/4)/55. The division by
  // 55 is a multiply by ceil(2^24/55) followed by a 24-bit shift.
  localparam logic [12:0] AuxFullMv  = 13'd3300;
  localparam logic [8:0]  AuxScale   = 9'd273;
  localparam logic [19:0] AuxRound   = 20'd110;
  localparam logic [18:0] AuxRecip   = 19'd305041;
  localparam int unsigned DivSteps   = 1;
  localparam int unsigned DivCntW    = 1;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_step;
    logic commit;
  } actd_cmd_t;

  typedef struct packed {
    logic need_div;
  } actd_status_t;

  // Volume bank index for a codec address; valid flag in the top bit.
  function automatic logic [4:0] vol_index(input logic [6:0] a);
    logic [4:0] r;
    unique case (a)
      7'h02:   r = {1'b1, 4'd0};
      7'h04:   r = {1'b1, 4'd1};
      7'h06:   r = {1'b1, 4'd2};
      7'h0a:   r = {1'b1, 4'd3};
      7'h0c:   r = {1'b1, 4'd4};
      7'h0e:   r = {1'b1, 4'd5};
      7'h10:   r = {1'b1, 4'd6};
      7'h12:   r = {1'b1, 4'd7};
      7'h14:   r = {1'b1, 4'd8};
      7'h16:   r = {1'b1, 4'd9};
      7'h18:   r = {1'b1, 4'd10};
      7'h1c:   r = {1'b1, 4'd11};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] vol_reset(input int unsigned i);
    logic [15:0] r;
    if (i < 4 || i == 11) r = 16'h8000;
    else if (i < 6) r = 16'h8008;
    else r = 16'h8808;
    return r;
  endfunction

endpackage

// ===== rtl/audio_codec_touch_digitizer.sv =====
// Top level of the codec register file and touch digitizer.
// Each transaction passes through capture, prep and exec states; an in-range aux update
// also passes a divide state, whose reciprocal multiply follows the registered scaled
// numerator. A new transaction is taken only after the previous one has committed.
// A finished result waits in the output register while the next transaction is taken.
// Reset (rst_ni low, asynchronous) restores all codec registers to their defaults.
module audio_codec_touch_digitizer import actd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic [6:0]         reg_addr_i,
  input  logic [15:0]        write_data_i,
  input  logic signed [15:0] pen_x_i,
  input  logic signed [15:0] pen_y_i,
  input  logic signed [15:0] pen_press_i,
  input  logic [1:0]         aux_pin_i,
  input  logic [15:0]        aux_millivolts_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               access_ok_o,
  output logic [15:0]        read_data_o,
  output logic               slot_valid_o,
  output logic [15:0]        slot_data_o
);

  // The controller sequences each transaction: capture, optional divide,
  // then a single commit cycle that updates state and loads the result.
  // The commit waits while the previous result is still held unaccepted.
  actd_cmd_t    cmd;
  actd_status_t status;

  actd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds every codec register and the digitizer state.
  actd_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .operation_i      (operation_i),
    .reg_addr_i       (reg_addr_i),
    .write_data_i     (write_data_i),
    .pen_x_i          (pen_x_i),
    .pen_y_i          (pen_y_i),
    .pen_press_i      (pen_press_i),
    .aux_pin_i        (aux_pin_i),
    .aux_millivolts_i (aux_millivolts_i),
    .access_ok_o      (access_ok_o),
    .read_data_o      (read_data_o),
    .slot_valid_o     (slot_valid_o),
    .slot_data_o      (slot_data_o)
  );

endmodule

// ===== rtl/actd_ctrl.sv =====
// Sequencing state machine of the codec touch digitizer.
module actd_ctrl import actd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  actd_status_t status_i,
  output actd_cmd_t    cmd_o
);
`include "audio_codec_touch_digitizer_defines.svh"

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPrep = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StExec = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StPrep;
        end
      end
      StPrep: begin
        if (status_i.need_div) begin
          cmd_o.div_start = 1'b1;
          cnt_d           = DivCntW'(DivSteps);
          state_d         = StDiv;
        end else begin
          state_d = StExec;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) state_d = StExec;
      end
      StExec: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ACTD_ASSERT(a_accept_leaves_idle, in_valid_i && in_ready_o |=> state_q == StPrep, "accept not followed by prep")
  `ACTD_NEVER(a_div_cnt_outside_div, cnt_q != '0 && state_q != StDiv, "divider count outside divide")
  `ACTD_NEVER(a_commit_overwrites, cmd_o.commit && out_valid_q && !out_ready_i, "result overwritten")

endmodule

// ===== rtl/actd_datapath.sv =====
// Register file, digitizer sequencing data, aux level scaler and result registers.
module actd_datapath import actd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  actd_cmd_t          cmd_i,
  output actd_status_t       status_o,
  input  logic [2:0]         operation_i,
  input  logic [6:0]         reg_addr_i,
  input  logic [15:0]        write_data_i,
  input  logic signed [15:0] pen_x_i,
  input  logic signed [15:0] pen_y_i,
  input  logic signed [15:0] pen_press_i,
  input  logic [1:0]         aux_pin_i,
  input  logic [15:0]        aux_millivolts_i,
  output logic               access_ok_o,
  output logic [15:0]        read_data_o,
  output logic               slot_valid_o,
  output logic [15:0]        slot_data_o
);

  // Captured transaction.
  logic [2:0]  op_q;
  logic [6:0]  addr_q;
  logic [15:0] wdata_q, px_q, py_q, pp_q, mv_q;
  logic [1:0]  pin_q;

  // Codec and digitizer state.
  logic [15:0] vol_q [12];
  logic [15:0] rec_q, gpr_q, pwr_q, ext_q, dac_q, adc_q, mix_q, fn_q, xfn_q;
  logic [15:0] d0_q, d1_q, res_q, pw0_q, pw1_q;
  logic [11:0] aux_q [4];
  logic [11:0] coord_q [3];
  logic        touch_q, unread_q;
  logic [1:0]  pcnt_q;

  // Aux level scaler: scaled numerator registered, then a reciprocal multiply.
  logic [17:0] n_q;
  logic [11:0] quo_q;
  logic [19:0] num;
  logic [35:0] prod;

  logic        ok_q, sv_q;
  logic [15:0] rd_q, sd_q;

  assign status_o.need_div = (op_q == OpAux) && (mv_q <= 16'(AuxFullMv));

  assign num  = 20'(mv_q[11:0]) * 20'(AuxScale) + AuxRound;
  assign prod = {18'd0, n_q} * {17'd0, AuxRecip};

  function automatic logic [15:0] reading(input logic [2:0] src, input logic touch,
                                          input logic [11:0] c0, input logic [11:0] c1,
                                          input logic [11:0] c2, input logic [11:0] a0,
                                          input logic [11:0] a1, input logic [11:0] a2,
                                          input logic [11:0] a3);
    logic [11:0] v;
    case (src)
      3'd1:    v = c0;
      3'd2:    v = c1;
      3'd3:    v = c2;
      3'd4:    v = a0;
      3'd5:    v = a1;
      3'd6:    v = a2;
      3'd7:    v = a3;
      default: v = 12'd0;
    endcase
    return {touch, src, v};
  endfunction

  logic [4:0]  vidx;
  logic        rw_hit, ok, sv, have, slot, blocked, take;
  logic [15:0] rw_val, rd, sd, w, y;
  logic [2:0]  taddr;

  assign vidx = vol_index(addr_q);

  always_comb begin
    rw_hit = 1'b1;
    rw_val = 16'd0;
    if (vidx[4]) begin
      rw_val = vol_q[vidx[3:0]];
    end else begin
      unique case (addr_q)
        AddrRecSel:  rw_val = rec_q;
        AddrGpr:     rw_val = gpr_q;
        AddrPwrDn:   rw_val = pwr_q;
        AddrExtAud:  rw_val = ext_q;
        AddrDacRate: rw_val = dac_q;
        AddrAdcRate: rw_val = adc_q;
        AddrMixMute: rw_val = mix_q;
        AddrFuncCtl: rw_val = fn_q;
        AddrExtraFn: rw_val = xfn_q;
        AddrDig0:    rw_val = d0_q;
        AddrDig1:    rw_val = d1_q;
        default:     rw_hit = 1'b0;
      endcase
    end
  end

  // Read result and tick decision for the captured transaction.
  always_comb begin
    ok      = 1'b0;
    rd      = 16'd0;
    if (op_q == OpRead) begin
      if (rw_hit) begin
        ok = 1'b1;
        rd = rw_val;
      end else begin
        unique case (addr_q)
          AddrReset:  begin ok = 1'b1; rd = ResetId;   end
          AddrResult: begin ok = 1'b1; rd = res_q;     end
          AddrId1:    begin ok = 1'b1; rd = VendorId1; end
          AddrId2:    begin ok = 1'b1; rd = VendorId2; end
          default:    ok = 1'b0;
        endcase
      end
    end else if (op_q == OpWrite) begin
      ok = rw_hit;
    end
    slot    = d0_q[3];
    blocked = (!slot && unread_q && d1_q[8]) || (slot && (d0_q[2:0] != 3'd0));
    taddr   = d0_q[14:12];
    take    = (op_q == OpTick) && !blocked && (pcnt_q == 2'd0) &&
              (d0_q[15] || touch_q || !d1_q[12]);
    have    = (op_q == OpTick) && !blocked && ((pcnt_q != 2'd0) || take);
    y       = reading(3'd2, touch_q, coord_q[0], coord_q[1], coord_q[2],
                      aux_q[0], aux_q[1], aux_q[2], aux_q[3]);
    if (pcnt_q != 2'd0) w = (pcnt_q >= 2'd2) ? pw0_q : pw1_q;
    else if (d0_q[11]) w = reading(3'd1, touch_q, coord_q[0], coord_q[1], coord_q[2],
                                   aux_q[0], aux_q[1], aux_q[2], aux_q[3]);
    else w = reading(taddr, touch_q, coord_q[0], coord_q[1], coord_q[2],
                     aux_q[0], aux_q[1], aux_q[2], aux_q[3]);
    sv = have && slot;
    sd = sv ? w : 16'd0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      addr_q  <= reg_addr_i;
      wdata_q <= write_data_i;
      px_q    <= pen_x_i;
      py_q    <= pen_y_i;
      pp_q    <= pen_press_i;
      pin_q   <= aux_pin_i;
      mv_q    <= aux_millivolts_i;
    end
    if (cmd_i.div_start) begin
      n_q   <= num[19:2];
    end else if (cmd_i.div_step) begin
      quo_q <= prod[35:24];
    end
    if (cmd_i.commit) begin
      ok_q <= ok;
      rd_q <= rd;
      sv_q <= sv;
      sd_q <= sd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 12; i++) vol_q[i] <= vol_reset(i);
      rec_q <= '0; gpr_q <= '0; pwr_q <= 16'h000f; ext_q <= '0;
      dac_q <= 16'hbb80; adc_q <= 16'hbb80; mix_q <= '0; fn_q <= '0; xfn_q <= '0;
      d0_q <= '0; d1_q <= '0; res_q <= '0; pw0_q <= '0; pw1_q <= '0;
      for (int i = 0; i < 4; i++) aux_q[i] <= '0;
      for (int i = 0; i < 3; i++) coord_q[i] <= '0;
      touch_q <= 1'b0; unread_q <= 1'b0; pcnt_q <= '0;
    end else if (cmd_i.commit) begin
      if (op_q == OpWrite && rw_hit) begin
        if (vidx[4]) begin
          vol_q[vidx[3:0]] <= wdata_q;
        end else begin
          unique case (addr_q)
            AddrRecSel:  rec_q <= wdata_q;
            AddrGpr:     gpr_q <= wdata_q;
            AddrPwrDn:   pwr_q <= wdata_q;
            AddrExtAud:  ext_q <= wdata_q;
            AddrDacRate: dac_q <= wdata_q;
            AddrAdcRate: adc_q <= wdata_q;
            AddrMixMute: mix_q <= wdata_q;
            AddrFuncCtl: fn_q  <= wdata_q;
            AddrExtraFn: xfn_q <= wdata_q;
            AddrDig0:    d0_q  <= wdata_q;
            AddrDig1:    d1_q  <= wdata_q;
            default:     ;
          endcase
        end
      end
      if (op_q == OpRead && addr_q == AddrResult) unread_q <= 1'b0;
      if (op_q == OpPen) begin
        touch_q <= !px_q[15] && !py_q[15] && !pp_q[15];
        if (!px_q[15] && !py_q[15] && !pp_q[15]) begin
          coord_q[0] <= px_q[11:0];
          coord_q[1] <= py_q[11:0];
          coord_q[2] <= pp_q[11:0];
        end
      end
      if (op_q == OpAux) begin
        aux_q[pin_q] <= (mv_q > 16'(AuxFullMv)) ? 12'hfff : quo_q;
      end
      if (have) begin
        if (pcnt_q != 2'd0) begin
          pcnt_q <= (pcnt_q >= 2'd2) ? 2'd1 : 2'd0;
        end else begin
          d0_q <= d0_q & 16'h7fff;
          if (d0_q[11]) begin
            if (taddr != 3'd0) begin
              pw0_q  <= y;
              pw1_q  <= reading(taddr, touch_q, coord_q[0], coord_q[1], coord_q[2],
                                aux_q[0], aux_q[1], aux_q[2], aux_q[3]);
              pcnt_q <= 2'd2;
            end else begin
              pw1_q  <= y;
              pcnt_q <= 2'd1;
            end
          end
        end
        if (!slot) begin
          res_q    <= w;
          unread_q <= 1'b1;
        end
      end
    end
  end

  assign access_ok_o  = ok_q;
  assign read_data_o  = rd_q;
  assign slot_valid_o = sv_q;
  assign slot_data_o  = sd_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the codec register file and touch digitizer.
`timescale 1ns / 1ps

module tb;
  import actd_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         operation_i = '0;
  logic [6:0]         reg_addr_i = '0;
  logic [15:0]        write_data_i = '0;
  logic signed [15:0] pen_x_i = '0;
  logic signed [15:0] pen_y_i = '0;
  logic signed [15:0] pen_press_i = '0;
  logic [1:0]         aux_pin_i = '0;
  logic [15:0]        aux_millivolts_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               access_ok_o;
  logic [15:0]        read_data_o;
  logic               slot_valid_o;
  logic [15:0]        slot_data_o;

  audio_codec_touch_digitizer DUT (.*);

  always #10 clk_i = ~clk_i;

  // One expected response of the codec.
  typedef struct packed {
    logic        ok;
    logic [15:0] rdata;
    logic        sv;
    logic [15:0] sdata;
  } codec_resp_t;

  codec_resp_t resp_q[$];

  // Shadow copy of the codec state.
  logic [15:0] vol_m[12];
  logic [15:0] rec_sel_m, gpr_m, pwr_m, ext_aud_m, dac_m, adc_m;
  logic [15:0] mix_m, fctl_m, xfn_m, res_m;
  logic [15:0] dig_m[2];
  logic [11:0] aux_m[4];
  logic [11:0] coord_m[3];
  logic        touch_m, unread_m;
  int          npend_m;
  logic [15:0] pend_m[2];

  int  errors = 0;
  int  cycles = 0;
  bit  idle_en = 1'b1;
  int  hold_cycles = 0;

  localparam int CycleLimit = 400000;

  function automatic void shadow_reset();
    for (int i = 0; i < 12; i++) begin
      vol_m[i] = (i < 4 || i == 11) ? 16'h8000 : (i < 6 ? 16'h8008 : 16'h8808);
    end
    rec_sel_m = '0; gpr_m = '0; pwr_m = 16'h000f; ext_aud_m = '0;
    dac_m = 16'hbb80; adc_m = 16'hbb80; mix_m = '0; fctl_m = '0; xfn_m = '0;
    dig_m[0] = '0; dig_m[1] = '0; res_m = '0;
    for (int i = 0; i < 4; i++) aux_m[i] = '0;
    for (int i = 0; i < 3; i++) coord_m[i] = '0;
    touch_m = 0; unread_m = 0; npend_m = 0; pend_m[0] = '0; pend_m[1] = '0;
  endfunction

  // Tagged digitizer word for one source address.
  function automatic logic [15:0] sample_word(logic [2:0] src);
    logic [15:0] v;
    if (src == 0) v = '0;
    else if (src <= 3) v = {4'd0, coord_m[src - 1]};
    else v = {4'd0, aux_m[src - 4]};
    v[15] = touch_m;
    v[14:12] = src;
    return v;
  endfunction

  // Register access: returns hit, read value and, for writes, stores data.
  function automatic logic reg_access(logic [6:0] a, logic wr, logic [15:0] d,
                                      output logic [15:0] q);
    logic [4:0] vi;
    logic hit;
    vi = '0;
    hit = 1'b1;
    q = '0;
    case (a)
      7'h02: vi = 5'd16; 7'h04: vi = 5'd17; 7'h06: vi = 5'd18; 7'h0a: vi = 5'd19;
      7'h0c: vi = 5'd20; 7'h0e: vi = 5'd21; 7'h10: vi = 5'd22; 7'h12: vi = 5'd23;
      7'h14: vi = 5'd24; 7'h16: vi = 5'd25; 7'h18: vi = 5'd26; 7'h1c: vi = 5'd27;
      default: vi = '0;
    endcase
    if (vi[4]) begin
      q = vol_m[vi[3:0]];
      if (wr) vol_m[vi[3:0]] = d;
      return 1'b1;
    end
    case (a)
      AddrRecSel:  begin q = rec_sel_m; if (wr) rec_sel_m = d; end
      AddrGpr:     begin q = gpr_m; if (wr) gpr_m = d; end
      AddrPwrDn:   begin q = pwr_m; if (wr) pwr_m = d; end
      AddrExtAud:  begin q = ext_aud_m; if (wr) ext_aud_m = d; end
      AddrDacRate: begin q = dac_m; if (wr) dac_m = d; end
      AddrAdcRate: begin q = adc_m; if (wr) adc_m = d; end
      AddrMixMute: begin q = mix_m; if (wr) mix_m = d; end
      AddrFuncCtl: begin q = fctl_m; if (wr) fctl_m = d; end
      AddrExtraFn: begin q = xfn_m; if (wr) xfn_m = d; end
      AddrDig0:    begin q = dig_m[0]; if (wr) dig_m[0] = d; end
      AddrDig1:    begin q = dig_m[1]; if (wr) dig_m[1] = d; end
      AddrReset:   begin q = ResetId; hit = !wr; end
      AddrResult:  begin q = res_m; hit = !wr; if (!wr) unread_m = 0; end
      AddrId1:     begin q = VendorId1; hit = !wr; end
      AddrId2:     begin q = VendorId2; hit = !wr; end
      default:     hit = 1'b0;
    endcase
    if (!hit) q = '0;
    return hit;
  endfunction

  // Frame tick of the digitizer; returns 1 when a word goes out in the slot.
  function automatic logic digitizer_tick(output logic [15:0] w);
    logic [15:0] d0, d1;
    logic slot;
    logic [2:0] src;
    d0 = dig_m[0];
    d1 = dig_m[1];
    slot = d0[3];
    w = '0;
    if (!slot && unread_m && d1[8]) return 1'b0;
    if (slot && d0[2:0] != 0) return 1'b0;
    if (npend_m != 0) begin
      w = pend_m[(npend_m >= 2) ? 0 : 1];
      npend_m = npend_m - 1;
    end else if (d0[15] || touch_m || !d1[12]) begin
      src = d0[14:12];
      dig_m[0] = d0 & 16'h7fff;
      if (d0[11]) begin
        w = sample_word(3'd1);
        if (src != 0) begin
          pend_m[0] = sample_word(3'd2);
          pend_m[1] = sample_word(src);
          npend_m = 2;
        end else begin
          pend_m[1] = sample_word(3'd2);
          npend_m = 1;
        end
      end else begin
        w = sample_word(src);
      end
    end else begin
      return 1'b0;
    end
    if (slot) return 1'b1;
    res_m = w;
    unread_m = 1;
    w = '0;
    return 1'b0;
  endfunction

  function automatic codec_resp_t predict_codec(logic [2:0] op, logic [6:0] a,
      logic [15:0] d, logic [15:0] x, logic [15:0] y, logic [15:0] p,
      logic [1:0] pin, logic [15:0] mv);
    codec_resp_t r;
    logic [15:0] q;
    logic [31:0] lvl;
    r = '0;
    case (op)
      OpRead: begin
        r.ok = reg_access(a, 1'b0, d, q);
        r.rdata = q;
      end
      OpWrite: r.ok = reg_access(a, 1'b1, d, q);
      OpTick:  begin
        r.sv = digitizer_tick(q);
        r.sdata = q;
      end
      OpPen: begin
        touch_m = !x[15] && !y[15] && !p[15];
        if (touch_m) begin
          coord_m[0] = x[11:0]; coord_m[1] = y[11:0]; coord_m[2] = p[11:0];
        end
      end
      OpAux: begin
        lvl = (mv > 3300) ? 32'h0fff : (32'(mv) * 4095 + 1650) / 3300;
        aux_m[pin] = lvl[11:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one transaction and holds it until the codec takes it.
  task automatic send_item(logic [2:0] op, logic [6:0] a = '0, logic [15:0] d = '0,
      logic [15:0] x = '0, logic [15:0] y = '0, logic [15:0] p = '0,
      logic [1:0] pin = '0, logic [15:0] mv = '0);
    while (idle_en && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op; reg_addr_i <= a; write_data_i <= d;
    pen_x_i <= x; pen_y_i <= y; pen_press_i <= p;
    aux_pin_i <= pin; aux_millivolts_i <= mv;
    do @(posedge clk_i); while (!in_ready_o);
    resp_q.push_back(predict_codec(op, a, d, x, y, p, pin, mv));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !idle_en || ($urandom_range(99) >= 38);
    end
  end

  // Compares each response with the oldest prediction.
  always @(posedge clk_i) begin
    codec_resp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (resp_q.size() == 0) begin
        $error("unexpected response");
        errors++;
      end else begin
        e = resp_q.pop_front();
        if (access_ok_o !== e.ok) begin
          $error("access_ok exp %0h got %0h", e.ok, access_ok_o); errors++;
        end
        if (read_data_o !== e.rdata) begin
          $error("read_data exp %0h got %0h", e.rdata, read_data_o); errors++;
        end
        if (slot_valid_o !== e.sv) begin
          $error("slot_valid exp %0h got %0h", e.sv, slot_valid_o); errors++;
        end
        if (slot_data_o !== e.sdata) begin
          $error("slot_data exp %0h got %0h", e.sdata, slot_data_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Every even address read; writes to the read-only ones, an unmapped address and GPR.
  task automatic test_register_map();
    for (int a = 0; a < 128; a += 2) send_item(OpRead, 7'(a));
    send_item(OpWrite, AddrReset, 16'hffff);
    send_item(OpWrite, AddrResult, 16'hffff);
    send_item(OpWrite, AddrId1, 16'h0000);
    send_item(OpWrite, AddrId2, 16'hffff);
    send_item(OpWrite, 7'h7f, 16'h1234);
    send_item(OpRead, 7'h03);
    send_item(OpWrite, AddrGpr, 16'hffff);
    send_item(OpRead, AddrGpr);
    send_item(OpWrite, AddrGpr, 16'h0000);
    send_item(OpRead, AddrGpr);
    send_item(3'd5); send_item(3'd6); send_item(3'd7);
  endtask

  // Pen extremes and aux rounding and saturation.
  task automatic test_pen_and_aux();
    send_item(OpPen, '0, '0, 16'h7fff, 16'h0000, 16'h7fff);
    send_item(OpPen, '0, '0, 16'h8000, 16'h0123, 16'h0456);
    send_item(OpPen, '0, '0, 16'h0123, 16'hffff, 16'h0456);
    send_item(OpPen, '0, '0, 16'h0123, 16'h0456, 16'h8000);
    send_item(OpAux, '0, '0, '0, '0, '0, 2'd0, 16'd0);
    send_item(OpAux, '0, '0, '0, '0, '0, 2'd1, 16'd3300);
    send_item(OpAux, '0, '0, '0, '0, '0, 2'd2, 16'd3301);
    send_item(OpAux, '0, '0, '0, '0, '0, 2'd3, 16'hffff);
    send_item(OpAux, '0, '0, '0, '0, '0, 2'd3, 16'd1);
  endtask

  // Register mode, slot mode, sets with and without a third reading.
  task automatic test_digitizer_modes();
    send_item(OpPen, '0, '0, 16'h0abc, 16'h0def, 16'h0321);
    send_item(OpWrite, AddrDig1, 16'h0100);
    send_item(OpWrite, AddrDig0, 16'h8000 | 16'h3000);
    send_item(OpTick);
    send_item(OpTick);
    send_item(OpRead, AddrResult);
    send_item(OpTick);
    send_item(OpWrite, AddrDig0, 16'h0808 | 16'h5000);
    repeat (4) send_item(OpTick);
    send_item(OpWrite, AddrDig0, 16'h0808);
    repeat (3) send_item(OpTick);
    send_item(OpWrite, AddrDig0, 16'h000b);
    send_item(OpTick);
    send_item(OpPen, '0, '0, 16'hffff, 16'hffff, 16'hffff);
    send_item(OpWrite, AddrDig1, 16'h1000);
    send_item(OpWrite, AddrDig0, 16'h0008);
    send_item(OpTick);
    send_item(OpWrite, AddrDig0, 16'h8008 | 16'h7000);
    send_item(OpTick);
  endtask

  // Receiver holds off while the sender keeps offering; then a full drain.
  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 20; i++) send_item(OpRead, AddrDacRate);
    wait_drained();
  endtask

  function automatic logic [6:0] pick_addr();
    logic [6:0] known[27];
    known = '{7'h00, 7'h02, 7'h04, 7'h06, 7'h0a, 7'h0c, 7'h0e, 7'h10,
        7'h12, 7'h14, 7'h16, 7'h18, 7'h1a, 7'h1c, 7'h20, 7'h26, 7'h2a, 7'h2c,
        7'h32, 7'h5a, 7'h5c, 7'h74, 7'h76, 7'h78, 7'h7a, 7'h7c, 7'h7e};
    if ($urandom_range(9) == 0) return 7'($urandom);
    return known[$urandom_range(26)];
  endfunction

  // Random mix, weighted toward digitizer traffic; mostly small aux levels.
  task automatic test_random(int n);
    int k;
    logic [6:0] a;
    logic [15:0] d;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) idle_en = 0;
      if (i == n / 2 + 150) idle_en = 1;
      k = $urandom_range(99);
      if (k < 30) send_item(OpTick);
      else if (k < 45) begin
        a = pick_addr();
        d = $urandom;
        if (a == AddrDig0 || a == AddrDig1 || $urandom_range(1)) begin
          a = $urandom_range(1) ? AddrDig0 : AddrDig1;
          if (a == AddrDig0) d = d & 16'hf80f & ($urandom_range(3) ? 16'hfff8 : 16'hffff);
        end
        send_item(OpWrite, a, d);
      end else if (k < 70) send_item(OpRead, $urandom_range(2) ? AddrResult : pick_addr());
      else if (k < 85) send_item(OpPen, '0, '0, $urandom_range(3) ? 16'($urandom & 16'h7fff)
          : 16'($urandom), 16'($urandom & 16'h7fff), $urandom_range(7) ?
          16'($urandom & 16'h7fff) : 16'($urandom));
      else if (k < 97) send_item(OpAux, '0, '0, '0, '0, '0, 2'($urandom),
          $urandom_range(3) ? 16'($urandom_range(3300)) : 16'($urandom));
      else send_item(3'($urandom_range(7, 5)), 7'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    shadow_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_map();
    test_pen_and_aux();
    test_digitizer_modes();
    test_backpressure();
    test_random(770);
    wait_drained();
    if (errors == 0 && resp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/actd_pkg.sv
rtl/actd_ctrl.sv
rtl/actd_datapath.sv
rtl/audio_codec_touch_digitizer.sv
tb/tb.sv
